// ----- hw/rtl/tmb_pkg.sv -----
// ----------------------------------------------------------------------------
// tmb_pkg
// Shared types and constants for the multi-slot timer bank.
// ----------------------------------------------------------------------------
package tmb_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int IDX_W     = $clog2(NUM_SLOTS);
   localparam int SLOT_W    = 4;
   localparam int TIME_W    = 32;
   localparam int CSR_W     = 32;
   localparam int ADDR_W    = 1;

   // (2^32-1)/10
   localparam logic [TIME_W-1:0] HB_RESET_PERIOD = TIME_W'(32'hFFFF_FFFF / 10);

   localparam logic [1:0] MODE_POLL  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_STOP  = 2'd2;

   localparam logic [ADDR_W-1:0] REG_HB_PERIOD = ADDR_W'(0);

   localparam logic RSP_EXPIRY  = 1'b0;
   localparam logic RSP_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      KIND_IDLE     = 2'd0,
      KIND_ONCE     = 2'd1,
      KIND_PERIODIC = 2'd2
   } slot_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HB,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] timeout;
      logic              periodic;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] fired_slot;
      logic [TIME_W-1:0] wait_time;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] base;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] remaining;
   } slot_entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_addr;
      slot_entry_type       wr_data;
      logic [IDX_W-1:0]     rd_addr;
   } ram_ctrl_type;

endpackage

// ----- hw/rtl/tmb_slot_ram.sv -----
// ----------------------------------------------------------------------------
// tmb_slot_ram
// Slot timing store: base, period and remaining time, one entry per slot.
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmb_slot_ram
   import tmb_pkg::*;
(
   input  logic           clock,
   input  ram_ctrl_type   ctrl,
   output slot_entry_type rd_data
);

   slot_entry_type mem [NUM_SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      rd_data_ff <= mem[ctrl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/tmb_csr.sv -----
// ----------------------------------------------------------------------------
// tmb_csr
// APB-style register file holding the heartbeat reload period.
// ----------------------------------------------------------------------------
module tmb_csr
   import tmb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]  prdata,
   output logic              pready,
   output logic [TIME_W-1:0] hb_period
);

   logic [TIME_W-1:0] hb_period_ff;
   logic [TIME_W-1:0] hb_period_in;
   logic              wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && pready && (paddr == REG_HB_PERIOD);

   always_comb begin
      hb_period_in = hb_period_ff;
      if (wr_hit) begin
         hb_period_in = pwdata[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_period_ff <= HB_RESET_PERIOD;
      end else begin
         hb_period_ff <= hb_period_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == REG_HB_PERIOD) begin
         prdata = CSR_W'(hb_period_ff);
      end
   end

   assign hb_period = hb_period_ff;

endmodule

// ----- hw/rtl/multi_slot_timer_bank_core.sv -----
// ----------------------------------------------------------------------------
// multi_slot_timer_bank_core
// Bank of one-shot / periodic timer slots plus a silent heartbeat timer.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Start and stop
// transactions are acknowledged on rsp_strobe in the cycle after they are
// taken, and busy never rises. A poll walks the slot store one entry per
// cycle (one read port, registered read data), then updates the heartbeat,
// then issues the summary; busy stays high through the walk, the heartbeat
// update and the summary. Expiry reports stream out in slot order while
// the walk runs, each one cycle wide, followed by the summary carrying the
// smallest remaining time and last set. Results cannot be held off: the
// receiver must take each one in the cycle it is strobed.
// ----------------------------------------------------------------------------
module multi_slot_timer_bank_core
   import tmb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // command channel
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   // result channel
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]  prdata,
   output logic              pready
);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              proc_vld_ff, proc_vld_in;
   logic [IDX_W-1:0]  proc_idx_ff, proc_idx_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] sleep_ff, sleep_in;
   logic [TIME_W-1:0] hb_base_ff, hb_base_in;
   logic [TIME_W-1:0] hb_rem_ff, hb_rem_in;
   slot_kind_type     kind_ff [NUM_SLOTS];
   slot_kind_type     kind_in [NUM_SLOTS];
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [TIME_W-1:0] hb_period;
   ram_ctrl_type      ram_ctrl;
   slot_entry_type    rd_entry;

   // slot datapath
   slot_kind_type     cur_kind;
   logic              cur_active;
   logic [TIME_W-1:0] elapsed;
   logic              fire;
   logic [TIME_W-1:0] new_rem;
   logic [TIME_W-1:0] hb_elapsed;
   logic              accept;
   logic              slot_ok;

   tmb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .hb_period (hb_period)
   );

   tmb_slot_ram u_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .rd_data (rd_entry)
   );

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign slot_ok = ({1'b0, req_data.slot} < (SLOT_W+1)'(NUM_SLOTS));

   // Read-modify-write of the slot fetched last cycle. Walk addresses never
   // repeat within a poll, so no forwarding is needed.
   assign cur_kind   = kind_ff[proc_idx_ff];
   assign cur_active = (cur_kind == KIND_ONCE) || (cur_kind == KIND_PERIODIC);
   assign elapsed    = now_ff - rd_entry.base;
   assign fire       = (elapsed >= rd_entry.remaining);
   assign new_rem    = fire ? rd_entry.period : (rd_entry.remaining - elapsed);
   assign hb_elapsed = now_ff - hb_base_ff;

   // ------------------------------------------------------------------
   // Next state and datapath
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      proc_vld_in   = 1'b0;
      proc_idx_in   = proc_idx_ff;
      now_in        = now_ff;
      sleep_in      = sleep_ff;
      hb_base_in    = hb_base_ff;
      hb_rem_in     = hb_rem_ff;
      kind_in       = kind_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      ram_ctrl.wr_en   = 1'b0;
      ram_ctrl.wr_addr = proc_idx_ff;
      ram_ctrl.wr_data = '{base: now_ff, period: rd_entry.period, remaining: new_rem};
      ram_ctrl.rd_addr = scan_idx_ff;

      // slot update from the previous read
      if (proc_vld_ff && cur_active) begin
         ram_ctrl.wr_en = 1'b1;
         if (fire) begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '{kind: RSP_EXPIRY, fired_slot: SLOT_W'(proc_idx_ff),
                              wait_time: '0, last: 1'b0};
            if (cur_kind == KIND_ONCE) begin
               kind_in[proc_idx_ff] = KIND_IDLE;
            end
         end
         if (!(fire && (cur_kind == KIND_ONCE)) && (new_rem < sleep_ff)) begin
            sleep_in = new_rem;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.mode == MODE_POLL) begin
                  state_in    = ST_SCAN;
                  scan_idx_in = '0;
                  now_in      = req_data.now;
                  sleep_in    = '1;
               end else begin
                  if (req_data.mode == MODE_START && slot_ok) begin
                     ram_ctrl.wr_en   = 1'b1;
                     ram_ctrl.wr_addr = IDX_W'(req_data.slot);
                     ram_ctrl.wr_data = '{base: req_data.now, period: req_data.timeout,
                                          remaining: req_data.timeout};
                     kind_in[IDX_W'(req_data.slot)] =
                        req_data.periodic ? KIND_PERIODIC : KIND_ONCE;
                  end else if (req_data.mode == MODE_STOP && slot_ok) begin
                     kind_in[IDX_W'(req_data.slot)] = KIND_IDLE;
                  end
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '{kind: RSP_SUMMARY, fired_slot: '0,
                                    wait_time: '0, last: 1'b1};
               end
            end
         end
         ST_SCAN: begin
            proc_vld_in = 1'b1;
            proc_idx_in = scan_idx_ff;
            if (scan_idx_ff == IDX_W'(NUM_SLOTS - 1)) begin
               state_in = ST_HB;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_HB: begin
            // last slot is still being written back this cycle
            hb_base_in = now_ff;
            hb_rem_in  = (hb_elapsed >= hb_rem_ff) ? hb_period : (hb_rem_ff - hb_elapsed);
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '{kind: RSP_SUMMARY, fired_slot: '0,
                              wait_time: (hb_rem_ff < sleep_ff) ? hb_rem_ff : sleep_ff,
                              last: 1'b1};
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_idx_ff   <= '0;
         proc_vld_ff   <= 1'b0;
         hb_base_ff    <= '0;
         hb_rem_ff     <= HB_RESET_PERIOD;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            kind_ff[i] <= KIND_IDLE;
         end
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         proc_vld_ff   <= proc_vld_in;
         hb_base_ff    <= hb_base_in;
         hb_rem_ff     <= hb_rem_in;
         rsp_strobe_ff <= rsp_strobe_in;
         kind_ff       <= kind_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      proc_idx_ff <= proc_idx_in;
      now_ff      <= now_in;
      sleep_ff    <= sleep_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- test/tb_multi_slot_timer_bank_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_slot_timer_bank_core
// Self-checking bench for the timer bank: directed start/stop/poll cases, then
// random command traffic under several heartbeat periods, all results checked
// in order against a cycle-free predictor of the slot store and heartbeat.
// ----------------------------------------------------------------------------
module tb_multi_slot_timer_bank_core;
   import tmb_pkg::*;

   // mode encoding the block must treat as a plain acknowledge
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // a poll and the longest sender gap both fit well inside this limit
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int ITEMS_PER_PHASE = 75;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_strobe;
   rsp_type           rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [CSR_W-1:0]  pwdata;
   logic [CSR_W-1:0]  prdata;
   logic              pready;

   // predicted copy of the bank
   slot_kind_type     tmr_kind   [NUM_SLOTS];
   logic [TIME_W-1:0] tmr_base   [NUM_SLOTS];
   logic [TIME_W-1:0] tmr_period [NUM_SLOTS];
   logic [TIME_W-1:0] tmr_left   [NUM_SLOTS];
   logic [TIME_W-1:0] hb_base;
   logic [TIME_W-1:0] hb_left;
   logic [TIME_W-1:0] hb_period;

   rsp_type           expected_rsp [$];
   int                err_count = 0;
   int                quiet_cycles = 0;
   bit                sender_gaps = 1'b1;
   // running system time for well-formed traffic
   logic [TIME_W-1:0] sys_now = '0;

   multi_slot_timer_bank_core uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      err_count++;
   endtask

   // Works out the results one accepted command causes and queues them.
   // Poll: every active slot, in index order, sees the same now; then the
   // heartbeat; then the summary with the smallest remaining time.
   function automatic void predict_results(input req_type cmd);
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] nap;
      rsp_type           res;
      if (cmd.mode == MODE_POLL) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tmr_kind[i] != KIND_IDLE) begin
               elapsed = cmd.now - tmr_base[i];
               tmr_base[i] = cmd.now;
               if (elapsed >= tmr_left[i]) begin
                  if (tmr_kind[i] == KIND_ONCE)
                     tmr_kind[i] = KIND_IDLE;
                  tmr_left[i] = tmr_period[i];
                  res = '0;
                  res.kind = RSP_EXPIRY;
                  res.fired_slot = SLOT_W'(i);
                  expected_rsp.push_back(res);
               end else begin
                  tmr_left[i] = tmr_left[i] - elapsed;
               end
            end
         end
         // heartbeat never reports; a new period only lands on reload
         elapsed = cmd.now - hb_base;
         hb_base = cmd.now;
         if (elapsed >= hb_left)
            hb_left = hb_period;
         else
            hb_left = hb_left - elapsed;
         nap = hb_left;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tmr_kind[i] != KIND_IDLE && tmr_left[i] < nap)
               nap = tmr_left[i];
         end
         res = '0;
         res.kind = RSP_SUMMARY;
         res.wait_time = nap;
         res.last = 1'b1;
         expected_rsp.push_back(res);
      end else begin
         // start/stop (any slot) and the unused mode: one plain acknowledge
         if (cmd.mode == MODE_START && cmd.slot < NUM_SLOTS) begin
            tmr_period[cmd.slot] = cmd.timeout;
            tmr_left[cmd.slot]   = cmd.timeout;
            tmr_base[cmd.slot]   = cmd.now;
            tmr_kind[cmd.slot]   = cmd.periodic ? KIND_PERIODIC : KIND_ONCE;
         end else if (cmd.mode == MODE_STOP && cmd.slot < NUM_SLOTS) begin
            tmr_kind[cmd.slot] = KIND_IDLE;
         end
         res = '0;
         res.kind = RSP_SUMMARY;
         res.last = 1'b1;
         expected_rsp.push_back(res);
      end
   endfunction

   function automatic req_type make_cmd(input logic [1:0] mode, input int slot,
                                        input logic [TIME_W-1:0] timeout,
                                        input logic periodic,
                                        input logic [TIME_W-1:0] now);
      req_type cmd;
      cmd = '0;
      cmd.mode     = mode;
      cmd.slot     = SLOT_W'(slot);
      cmd.timeout  = timeout;
      cmd.periodic = periodic;
      cmd.now      = now;
      return cmd;
   endfunction

   // Presents one command and holds it until the block takes it. start is
   // left high so the next command can follow without a bubble; a random
   // gap lowers it once.
   task automatic send_cmd(input req_type cmd);
      int unsigned gap;
      req_data <= cmd;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predict_results(cmd);
      if (sender_gaps && $urandom_range(2, 0) == 0) begin
         gap = $urandom_range(13, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop issuing commands and let every outstanding result come back.
   task automatic await_idle();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Register write followed by a read-back; only called with the bank idle.
   task automatic program_heartbeat(input logic [CSR_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_HB_PERIOD;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      hb_period = value;
      // psel stays up: straight into the read setup phase
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== value)
         report_error($sformatf("heartbeat_period read back %h, wrote %h", prdata, value));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed traffic on a forward-moving clock, with short
   // timeouts so slots keep expiring; the rest is time jumps and noise.
   function automatic req_type make_random_cmd();
      req_type     cmd;
      int unsigned pick;
      cmd = '0;
      cmd.slot     = SLOT_W'($urandom_range(NUM_SLOTS - 1, 0));
      cmd.periodic = 1'($urandom_range(1, 0));
      pick = $urandom_range(99, 0);
      if (pick < 5)
         cmd.timeout = '0;
      else if (pick < 65)
         cmd.timeout = $urandom_range(64, 1);
      else if (pick < 85)
         cmd.timeout = $urandom_range(2000, 65);
      else if (pick < 95)
         cmd.timeout = $urandom();
      else
         cmd.timeout = '1;
      pick = $urandom_range(99, 0);
      if (pick < 45) begin
         cmd.mode = MODE_POLL;
         sys_now = sys_now + $urandom_range(40, 0);
         cmd.now = sys_now;
      end else if (pick < 75) begin
         cmd.mode = MODE_START;
         cmd.now = sys_now;
      end else if (pick < 87) begin
         cmd.mode = MODE_STOP;
         cmd.now = $urandom();
      end else if (pick < 92) begin
         // big jump forward, usually fires everything
         cmd.mode = MODE_POLL;
         sys_now = sys_now + $urandom();
         cmd.now = sys_now;
      end else if (pick < 98) begin
         // noise: any mode, time unrelated to the running clock
         cmd.mode = 2'($urandom_range(3, 0));
         cmd.now = $urandom();
      end else begin
         cmd.mode = MODE_UNUSED;
         cmd.now = $urandom();
      end
      return cmd;
   endfunction

   // Empty bank poll, unused mode with every bit set, stop of an idle slot.
   task automatic test_empty_bank();
      send_cmd(make_cmd(MODE_POLL, 0, '0, 1'b0, '0));
      send_cmd(make_cmd(MODE_UNUSED, NUM_SLOTS - 1, '1, 1'b1, '1));
      send_cmd(make_cmd(MODE_STOP, 3, '0, 1'b0, '0));
   endtask

   // One-shot with zero period, periodic at max timeout across the time
   // wrap, restart of an active slot, stop of a running periodic.
   task automatic test_single_timers();
      send_cmd(make_cmd(MODE_START, 0, '0, 1'b0, '0));
      send_cmd(make_cmd(MODE_START, NUM_SLOTS - 1, '1, 1'b1, '1));
      send_cmd(make_cmd(MODE_POLL, 0, '0, 1'b0, '0));
      send_cmd(make_cmd(MODE_START, NUM_SLOTS - 1, 32'd10, 1'b1, '0));
      send_cmd(make_cmd(MODE_POLL, 0, '0, 1'b0, 32'd10));
      send_cmd(make_cmd(MODE_STOP, NUM_SLOTS - 1, '0, 1'b0, '0));
      send_cmd(make_cmd(MODE_POLL, 0, '0, 1'b0, 32'd20));
      sys_now = 32'd20;
   endtask

   // Every slot periodic, slot i with timeout i: one poll fires all of
   // them (largest burst), the next only the zero-period slot.
   task automatic test_full_bank();
      sys_now = 32'd100;
      for (int i = 0; i < NUM_SLOTS; i++)
         send_cmd(make_cmd(MODE_START, i, TIME_W'(i), 1'b1, sys_now));
      sys_now = sys_now + NUM_SLOTS;
      send_cmd(make_cmd(MODE_POLL, 0, '0, 1'b0, sys_now));
      send_cmd(make_cmd(MODE_POLL, 0, '0, 1'b0, sys_now));
   endtask

   // Random phases, each under its own heartbeat period (both extremes
   // among them); the final phase runs with no sender gaps.
   task automatic test_random_traffic();
      logic [CSR_W-1:0] period;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: period = 32'd1;
            1: period = $urandom_range(300, 2);
            2: period = '1;
            default: period = $urandom() | 32'd1;
         endcase
         await_idle();
         program_heartbeat(period);
         sender_gaps = (phase != 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_cmd(make_random_cmd());
      end
   endtask

   // Result checker: each strobed result is compared with the oldest
   // expectation. Outputs are sampled at the edge that ends their cycle.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            report_error($sformatf("unexpected result %p", rsp_data));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.kind !== want.kind)
               report_error($sformatf("kind got %b want %b", rsp_data.kind, want.kind));
            if (rsp_data.fired_slot !== want.fired_slot)
               report_error($sformatf("fired_slot got %0d want %0d",
                                      rsp_data.fired_slot, want.fired_slot));
            if (rsp_data.wait_time !== want.wait_time)
               report_error($sformatf("wait_time got %0d want %0d",
                                      rsp_data.wait_time, want.wait_time));
            if (rsp_data.last !== want.last)
               report_error($sformatf("last got %b want %b", rsp_data.last, want.last));
         end
      end
   end

   // Watchdog: any command, result or register transfer counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable && pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      // predictor reset state
      for (int i = 0; i < NUM_SLOTS; i++) begin
         tmr_kind[i]   = KIND_IDLE;
         tmr_base[i]   = '0;
         tmr_period[i] = '0;
         tmr_left[i]   = '0;
      end
      hb_period = HB_RESET_PERIOD;
      hb_left   = HB_RESET_PERIOD;
      hb_base   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_bank();
      test_single_timers();
      test_full_bank();
      test_random_traffic();

      // drain, then keep watching for results the block should not send
      await_idle();
      repeat (NUM_SLOTS + 4) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_rsp.size()));
      if (err_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
